// File: design/rrca_pkg.sv
package rrca_pkg;

  // Fixed geometry, set by the field widths of the channels.
  localparam int PORTS        = 4;
  localparam int SLOTS        = 2;
  localparam int PAYLOAD_BITS = 8;
  localparam int PORT_W       = 2;
  localparam int SLOT_W       = 1;
  localparam int COUNT_W      = 4;

  // Default FIFO depth per input port.
  localparam int DEF_QUEUE_DEPTH = 8;

  // Depths of the decoupling queues.
  localparam int CMD_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  // Configuration register widths and reset values.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int ACTIVE_W   = 3;
  localparam int SLOTS_W    = 2;
  localparam int LIMIT_W    = 5;

  localparam logic [ACTIVE_W-1:0]       ACTIVE_RESET = ACTIVE_W'(4);
  localparam logic [SLOTS_W-1:0]        SLOTS_RESET  = SLOTS_W'(2);
  localparam logic signed [LIMIT_W-1:0] LIMIT_NONE   = {LIMIT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_ROUND   = 2'd2
  } rrca_cmd_e;

  typedef enum logic [1:0] {
    KIND_ENQ_ACK = 2'd0,
    KIND_MOVED   = 2'd1,
    KIND_FREED   = 2'd2,
    KIND_DONE    = 2'd3
  } rrca_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_PORTS    = 2'd0,
    CFG_SLOTS_IN_USE    = 2'd1,
    CFG_EVENTS_PER_PORT = 2'd2
  } rrca_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SLOT,
    ST_DONE
  } rrca_state_e;

  // Input item as it arrives on the port.
  typedef struct packed {
    logic [1:0]              cmd;
    logic [PORT_W-1:0]       port;
    logic [PORT_W-1:0]       dest;
    logic [SLOT_W-1:0]       slot;
    logic [PAYLOAD_BITS-1:0] payload;
  } rrca_item_t;

  // Decoded operation handed from the front end to the engine.
  typedef struct packed {
    rrca_cmd_e               op;
    logic [PORT_W-1:0]       port;
    logic [PORT_W-1:0]       dest;
    logic [SLOT_W-1:0]       slot;
    logic [PAYLOAD_BITS-1:0] payload;
  } rrca_op_t;

  // One queued event.
  typedef struct packed {
    logic [PORT_W-1:0]       dest;
    logic [PAYLOAD_BITS-1:0] payload;
  } rrca_event_t;

  // One result item.
  typedef struct packed {
    rrca_kind_e              kind;
    logic                    ok;
    logic [PORT_W-1:0]       src_port;
    logic [PORT_W-1:0]       out_dest;
    logic [SLOT_W-1:0]       out_slot;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [COUNT_W-1:0]      move_total;
    logic                    last;
  } rrca_result_t;

endpackage

// File: design/rrca_fifo.sv
module rrca_fifo
  import rrca_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry_r[rd_ptr_r];

  // Pointer and fill count update for each transfer.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: design/rrca_front.sv
module rrca_front
  import rrca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  rrca_item_t in_data,
  input  logic       q_full,
  output logic       q_push,
  output rrca_op_t   q_data
);

  logic     valid_r, valid_nxt;
  rrca_op_t op_r, op_nxt;
  logic     accept;
  logic     legal;

  assign full   = valid_r && q_full;
  assign accept = push && !full;
  assign q_push = valid_r && !q_full;
  assign q_data = op_r;

  // Decode the command; an unknown code is dropped here and never reaches the engine.
  always_comb begin
    legal          = 1'b0;
    op_nxt         = op_r;
    op_nxt.port    = in_data.port;
    op_nxt.dest    = in_data.dest;
    op_nxt.slot    = in_data.slot;
    op_nxt.payload = in_data.payload;
    unique case (in_data.cmd)
      CMD_ENQUEUE: begin
        legal     = 1'b1;
        op_nxt.op = CMD_ENQUEUE;
      end
      CMD_FREE: begin
        legal     = 1'b1;
        op_nxt.op = CMD_FREE;
      end
      CMD_ROUND: begin
        legal     = 1'b1;
        op_nxt.op = CMD_ROUND;
      end
      default: begin
        legal = 1'b0;
      end
    endcase
  end

  // Holding stage: a new item may load in the cycle the old one moves on.
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = legal;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_nxt;
    end
  end

endmodule

// File: design/rrca_engine.sv
module rrca_engine
  import rrca_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  cmd_empty,
  input  rrca_op_t              cmd_data,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output rrca_result_t          res_data
);

  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(PORTS * QUEUE_DEPTH);

  // Configuration registers.
  logic [ACTIVE_W-1:0]       active_r;
  logic [SLOTS_W-1:0]        slots_r;
  logic signed [LIMIT_W-1:0] limit_r;

  // Queue bookkeeping and output slot state.
  logic [CW-1:0]                      cnt_r   [PORTS];
  logic [CW-1:0]                      cnt_nxt [PORTS];
  logic [HW-1:0]                      head_r  [PORTS];
  logic [HW-1:0]                      head_nxt[PORTS];
  logic [PORTS-1:0][SLOTS-1:0]        busy_r, busy_nxt;
  logic [PAYLOAD_BITS-1:0]            slot_pay_r [PORTS][SLOTS];

  // Round sequencer.
  rrca_state_e         state_r, state_nxt;
  logic [PORT_W-1:0]   start_r, start_nxt;
  logic [PORT_W-1:0]   cur_r, cur_nxt;
  logic [PORT_W-1:0]   visit_r, visit_nxt;
  logic [LIMIT_W-2:0]  j_r, j_nxt;
  logic [COUNT_W-1:0]  moved_r, moved_nxt;
  logic [ACTIVE_W-1:0] n_r, n_nxt;
  logic [SLOTS_W-1:0]  ns_r, ns_nxt;

  // Event memory.
  rrca_event_t qmem [PORTS * QUEUE_DEPTH];
  rrca_event_t rd_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  rrca_event_t mem_wdata;

  // Slot payload write.
  logic                    pay_we;
  logic [PORT_W-1:0]       pay_dest;
  logic [SLOT_W-1:0]       pay_slot;
  logic [PAYLOAD_BITS-1:0] pay_data;

  // Next state and outputs of the sequencer.
  always_comb begin
    logic               limit_ok;
    logic               last_port;
    logic [PORT_W-1:0]  cur_adv;
    logic               found;
    logic [SLOT_W-1:0]  fs;
    logic [CW:0]        pos_sum;
    logic [HW-1:0]      pos;
    logic               enq_ok;
    logic               free_ok;
    logic [ACTIVE_W-1:0] n_new;
    logic [PORT_W-1:0]  start_fix;

    state_nxt = state_r;
    start_nxt = start_r;
    cur_nxt   = cur_r;
    visit_nxt = visit_r;
    j_nxt     = j_r;
    moved_nxt = moved_r;
    n_nxt     = n_r;
    ns_nxt    = ns_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    busy_nxt  = busy_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res_data  = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    pay_we    = 1'b0;
    pay_dest  = rd_q.dest;
    pay_slot  = '0;
    pay_data  = rd_q.payload;

    // Move limit for the port under visit; minus one lifts it.
    limit_ok = (limit_r == LIMIT_NONE) ||
               (!limit_r[LIMIT_W-1] && ({1'b0, j_r} < $unsigned(limit_r)));

    // Step to the next active port of the round.
    last_port = ({1'b0, visit_r} == (n_r - ACTIVE_W'(1)));
    cur_adv   = (({1'b0, cur_r} + ACTIVE_W'(1)) == n_r) ? '0 : cur_r + PORT_W'(1);

    // Lowest free usable slot of the head event's destination.
    found = 1'b0;
    fs    = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!found && (SLOTS_W'(s) < ns_r) && !busy_r[rd_q.dest][s]) begin
        found = 1'b1;
        fs    = SLOT_W'(s);
      end
    end

    // Tail position of the addressed port's queue.
    pos_sum = (CW+1)'(head_r[cmd_data.port]) + (CW+1)'(cnt_r[cmd_data.port]);
    if (pos_sum >= (CW+1)'(QUEUE_DEPTH)) begin
      pos = HW'(pos_sum - (CW+1)'(QUEUE_DEPTH));
    end else begin
      pos = HW'(pos_sum);
    end
    enq_ok  = (cnt_r[cmd_data.port] < CW'(QUEUE_DEPTH));
    free_ok = busy_r[cmd_data.dest][cmd_data.slot];

    // Round setup: clamp the active port count and the start port.
    if (active_r == '0) begin
      n_new = ACTIVE_W'(1);
    end else if (active_r > ACTIVE_W'(PORTS)) begin
      n_new = ACTIVE_W'(PORTS);
    end else begin
      n_new = active_r;
    end
    start_fix = ({1'b0, start_r} >= n_new) ? '0 : start_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd_data.op)
            CMD_ENQUEUE: begin
              if (enq_ok) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cmd_data.port) * AW'(QUEUE_DEPTH) + AW'(pos);
                mem_wdata.dest    = cmd_data.dest;
                mem_wdata.payload = cmd_data.payload;
                cnt_nxt[cmd_data.port] = cnt_r[cmd_data.port] + CW'(1);
              end
              res_push             = 1'b1;
              res_data.kind        = KIND_ENQ_ACK;
              res_data.ok          = enq_ok;
              res_data.src_port    = cmd_data.port;
              res_data.out_dest    = cmd_data.dest;
              res_data.out_payload = cmd_data.payload;
              res_data.last        = 1'b1;
            end
            CMD_FREE: begin
              busy_nxt[cmd_data.dest][cmd_data.slot] = 1'b0;
              res_push             = 1'b1;
              res_data.kind        = KIND_FREED;
              res_data.ok          = free_ok;
              res_data.out_dest    = cmd_data.dest;
              res_data.out_slot    = cmd_data.slot;
              res_data.out_payload = free_ok ?
                                     slot_pay_r[cmd_data.dest][cmd_data.slot] : '0;
              res_data.last        = 1'b1;
            end
            CMD_ROUND: begin
              n_nxt     = n_new;
              ns_nxt    = (slots_r > SLOTS_W'(SLOTS)) ? SLOTS_W'(SLOTS) : slots_r;
              start_nxt = start_fix;
              cur_nxt   = start_fix;
              visit_nxt = '0;
              j_nxt     = '0;
              moved_nxt = '0;
              state_nxt = ST_HEAD;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_HEAD: begin
        if (limit_ok && (cnt_r[cur_r] != '0)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(cur_r) * AW'(QUEUE_DEPTH) + AW'(head_r[cur_r]);
          state_nxt = ST_SLOT;
        end else begin
          state_nxt = last_port ? ST_DONE : ST_HEAD;
          cur_nxt   = cur_adv;
          visit_nxt = visit_r + PORT_W'(1);
          j_nxt     = '0;
        end
      end
      ST_SLOT: begin
        if (!found) begin
          // Head of line blocked: leave this port.
          state_nxt = last_port ? ST_DONE : ST_HEAD;
          cur_nxt   = cur_adv;
          visit_nxt = visit_r + PORT_W'(1);
          j_nxt     = '0;
        end else if (!res_full) begin
          busy_nxt[rd_q.dest][fs] = 1'b1;
          pay_we   = 1'b1;
          pay_slot = fs;
          head_nxt[cur_r] = (head_r[cur_r] == HW'(QUEUE_DEPTH - 1)) ?
                            '0 : head_r[cur_r] + HW'(1);
          cnt_nxt[cur_r]  = cnt_r[cur_r] - CW'(1);
          j_nxt           = j_r + (LIMIT_W-1)'(1);
          moved_nxt       = moved_r + COUNT_W'(1);
          res_push             = 1'b1;
          res_data.kind        = KIND_MOVED;
          res_data.ok          = 1'b1;
          res_data.src_port    = cur_r;
          res_data.out_dest    = rd_q.dest;
          res_data.out_slot    = fs;
          res_data.out_payload = rd_q.payload;
          state_nxt            = ST_HEAD;
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push             = 1'b1;
          res_data.kind        = KIND_DONE;
          res_data.ok          = 1'b1;
          res_data.move_total  = moved_r;
          res_data.last        = 1'b1;
          start_nxt = (({1'b0, start_r} + ACTIVE_W'(1)) == n_r) ?
                      '0 : start_r + PORT_W'(1);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= '0;
      cur_r   <= '0;
      visit_r <= '0;
      j_r     <= '0;
      moved_r <= '0;
      n_r     <= ACTIVE_W'(1);
      ns_r    <= '0;
      busy_r  <= '0;
      for (int p = 0; p < PORTS; p++) begin
        cnt_r[p]  <= '0;
        head_r[p] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      cur_r   <= cur_nxt;
      visit_r <= visit_nxt;
      j_r     <= j_nxt;
      moved_r <= moved_nxt;
      n_r     <= n_nxt;
      ns_r    <= ns_nxt;
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
    end
  end

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
      slots_r  <= SLOTS_RESET;
      limit_r  <= LIMIT_NONE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ACTIVE_PORTS:    active_r <= cfg_wdata[ACTIVE_W-1:0];
        CFG_SLOTS_IN_USE:    slots_r  <= cfg_wdata[SLOTS_W-1:0];
        CFG_EVENTS_PER_PORT: limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Event memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      qmem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q <= qmem[mem_raddr];
    end
  end

  // Payloads held in the output slots.
  always_ff @(posedge clk) begin
    if (pay_we) begin
      slot_pay_r[pay_dest][pay_slot] <= pay_data;
    end
  end

  // A round never moves more events than there are output slots.
  a_moved_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (moved_r <= COUNT_W'(PORTS * SLOTS)))
    else $error("round moved more events than slots exist");

  // The memory read is only issued for a port that holds an event.
  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SLOT) |-> (cnt_r[cur_r] != '0))
    else $error("slot search on an empty queue");

  // The fill count of the port under visit stays within the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[cur_r] <= CW'(QUEUE_DEPTH))
    else $error("queue fill count overflow");

  // The slot search is only entered right after a head read.
  a_slot_after_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SLOT && $past(state_r) != ST_SLOT) |-> ($past(state_r) == ST_HEAD))
    else $error("slot search entered without a head read");

endmodule

// File: design/round_robin_crossbar_arbiter_unit.sv
// Channel   Ports                            Transfer when
// input     push, full, in_data              push && !full
// result    empty, pop, out_data             pop && !empty
// config    cfg_we, cfg_idx, cfg_wdata       cfg_we
//
// A round visits the N active ports in turn; each moved event takes a head read of
// the event memory and then the slot search, and a port is left at an empty queue,
// at its move limit or on a blocked head.
// Reset is synchronous and active low; queues, slots and start port clear at once.
// A full result queue stalls the engine, which then fills the command queue and
// raises full; the front end keeps taking items while the engine works.
module round_robin_crossbar_arbiter_unit
  import rrca_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  rrca_item_t            in_data,
  output logic                  empty,
  input  logic                  pop,
  output rrca_result_t          out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  rrca_op_t     q_wdata, q_rdata;
  logic         q_push, q_full, q_pop, q_empty;
  rrca_result_t res_data;
  logic         res_push, res_full;

  // Front end: takes items and decodes commands.
  rrca_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // Command queue between the front end and the engine.
  rrca_fifo #(
    .WIDTH ($bits(rrca_op_t)),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Engine: queues, slots and the arbitration round.
  rrca_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd_empty (q_empty),
    .cmd_data  (q_rdata),
    .cmd_pop   (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // Result queue toward the consumer.
  rrca_fifo #(
    .WIDTH ($bits(rrca_result_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

endmodule

// File: tb/round_robin_crossbar_arbiter_unit_test.sv
module round_robin_crossbar_arbiter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrca_pkg::*;

  localparam int QDEPTH = DEF_QUEUE_DEPTH;
  // The block takes no action on the one command code left over.
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  // Settling margin for the longest round, plus the decoupling queues.
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int WATCHDOG_NS = 10_000_000;

  typedef struct {
    bit            is_cfg;
    rrca_cfg_idx_e idx;
    logic [4:0]    value;
    rrca_item_t    item;
    bit            has_lit;
    rrca_result_t  lit;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  rrca_item_t            in_data;
  logic                  empty;
  logic                  pop;
  rrca_result_t          out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the arbiter state and its registers.
  rrca_event_t        fifo_mem [PORTS][QDEPTH];
  int                 fifo_count [PORTS];
  int                 fifo_head [PORTS];
  bit                 slot_taken [PORTS][SLOTS];
  logic [7:0]         slot_tag [PORTS][SLOTS];
  int                 rr_start;
  logic [2:0]         ports_active = ACTIVE_RESET;
  logic [1:0]         slots_usable = SLOTS_RESET;
  logic signed [4:0]  moves_per_port = LIMIT_NONE;

  rrca_result_t item_results[$];
  rrca_result_t awaited_results[$];
  plan_row_t    plan[$];
  int           mismatches;
  int           results_seen;
  int           send_calm;
  int           recv_calm;

  always #10 clk = ~clk;

  round_robin_crossbar_arbiter_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Works out the results one input item causes and updates the shadow state.
  function automatic void arbitrate_item(rrca_item_t it);
    rrca_result_t r;
    rrca_event_t  ev;
    int n, ns, cur, s, moved, taken, i;
    item_results.delete();
    r = '0;
    r.last = 1'b1;
    case (it.cmd)
      CMD_ENQUEUE: begin
        r.kind = KIND_ENQ_ACK;
        r.src_port = it.port;
        r.out_dest = it.dest;
        r.out_payload = it.payload;
        if (fifo_count[it.port] < QDEPTH) begin
          fifo_mem[it.port][(fifo_head[it.port] + fifo_count[it.port]) % QDEPTH] =
            '{dest: it.dest, payload: it.payload};
          fifo_count[it.port]++;
          r.ok = 1'b1;
        end
        item_results.push_back(r);
      end
      CMD_FREE: begin
        r.kind = KIND_FREED;
        r.out_dest = it.dest;
        r.out_slot = it.slot;
        if (slot_taken[it.dest][it.slot]) begin
          r.ok = 1'b1;
          r.out_payload = slot_tag[it.dest][it.slot];
          slot_taken[it.dest][it.slot] = 1'b0;
        end
        item_results.push_back(r);
      end
      CMD_ROUND: begin
        n = int'(ports_active);
        if (n == 0) n = 1;
        if (n > PORTS) n = PORTS;
        ns = (slots_usable > SLOTS) ? SLOTS : int'(slots_usable);
        if (rr_start >= n) rr_start = 0;
        cur = rr_start;
        moved = 0;
        for (i = 0; i < n; i++) begin
          taken = 0;
          // Drain the head of this port until it is empty, blocked or at its limit.
          while (moves_per_port == -1 || taken < moves_per_port) begin
            if (fifo_count[cur] == 0) break;
            ev = fifo_mem[cur][fifo_head[cur]];
            for (s = 0; s < ns; s++)
              if (!slot_taken[ev.dest][s]) break;
            if (s == ns) break;
            slot_taken[ev.dest][s] = 1'b1;
            slot_tag[ev.dest][s] = ev.payload;
            r = '0;
            r.kind = KIND_MOVED;
            r.ok = 1'b1;
            r.src_port = PORT_W'(cur);
            r.out_dest = ev.dest;
            r.out_slot = SLOT_W'(s);
            r.out_payload = ev.payload;
            item_results.push_back(r);
            moved++;
            fifo_head[cur] = (fifo_head[cur] + 1) % QDEPTH;
            fifo_count[cur]--;
            taken++;
          end
          cur = (cur + 1) % n;
        end
        rr_start = (rr_start + 1) % n;
        r = '0;
        r.kind = KIND_DONE;
        r.ok = 1'b1;
        r.move_total = COUNT_W'(moved);
        r.last = 1'b1;
        item_results.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic rrca_item_t op(logic [1:0] c, logic [1:0] p, logic [1:0] d, logic s,
                                    logic [7:0] pay);
    return '{cmd: c, port: p, dest: d, slot: s, payload: pay};
  endfunction

  function automatic rrca_result_t res(rrca_kind_e k, logic ok, logic [1:0] src,
                                       logic [1:0] d, logic s, logic [7:0] pay,
                                       logic [3:0] cnt);
    return '{kind: k, ok: ok, src_port: src, out_dest: d, out_slot: s, out_payload: pay,
             move_total: cnt, last: 1'b1};
  endfunction

  function automatic plan_row_t plain(rrca_item_t it);
    return '{is_cfg: 1'b0, idx: CFG_ACTIVE_PORTS, value: '0, item: it, has_lit: 1'b0,
             lit: '0};
  endfunction

  function automatic plan_row_t known(rrca_item_t it, rrca_result_t lit);
    return '{is_cfg: 1'b0, idx: CFG_ACTIVE_PORTS, value: '0, item: it, has_lit: 1'b1,
             lit: lit};
  endfunction

  function automatic plan_row_t setting(rrca_cfg_idx_e idx, logic [4:0] value);
    return '{is_cfg: 1'b1, idx: idx, value: value, item: '0, has_lit: 1'b0, lit: '0};
  endfunction

  // Cycles to hold off before the next transfer; now and then a run with no gaps.
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t ns: ERROR: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  task automatic check_result(rrca_result_t got);
    rrca_result_t want;
    results_seen++;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result %0d (kind %0d) arrived with none expected",
                                results_seen, got.kind));
      return;
    end
    want = awaited_results.pop_front();
    compare_field("kind", got.kind, want.kind);
    compare_field("ok", got.ok, want.ok);
    compare_field("src_port", got.src_port, want.src_port);
    compare_field("out_dest", got.out_dest, want.out_dest);
    compare_field("out_slot", got.out_slot, want.out_slot);
    compare_field("out_payload", got.out_payload, want.out_payload);
    compare_field("move_total", got.move_total, want.move_total);
    compare_field("last", got.last, want.last);
  endtask

  // Offers one item until the block takes the transfer, then records its results.
  task automatic send_item(rrca_item_t it, bit has_lit, rrca_result_t lit);
    int gap;
    @(negedge clk);
    push = 1'b1;
    in_data = it;
    do @(posedge clk); while (full);
    arbitrate_item(it);
    if (has_lit)
      awaited_results.push_back(lit);
    else
      foreach (item_results[k]) awaited_results.push_back(item_results[k]);
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      @(negedge clk);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Waits until every expected result has come back or the guard runs out, then lets the engine settle.
  task automatic wait_idle();
    int guard;
    @(negedge clk);
    push = 1'b0;
    for (guard = 0; awaited_results.size() != 0 && guard < DRAIN_LIMIT; guard++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(rrca_cfg_idx_e idx, logic [4:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_ACTIVE_PORTS:    ports_active = value[2:0];
      CFG_SLOTS_IN_USE:    slots_usable = value[1:0];
      CFG_EVENTS_PER_PORT: moves_per_port = value;
      default: begin
      end
    endcase
  endtask

  // Result side: pops with random stalls and checks each transfer.
  initial begin
    int gap;
    pop = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        @(negedge clk);
        pop = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      pop = 1'b1;
      do @(posedge clk); while (empty);
      check_result(out_data);
    end
  end

  // Stimulus: directed table first, then random phases under changing settings.
  initial begin
    rrca_item_t   it;
    logic [4:0]   p_val, s_val, l_val;
    int           phase, sent, pick, k;
    int           busy_codes[$];
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_ACTIVE_PORTS;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Field extremes, rejected operations and the unknown command.
    plan.push_back(known(op(CMD_ENQUEUE, 0, 1, 0, 8'h00),
                         res(KIND_ENQ_ACK, 1, 0, 1, 0, 8'h00, 0)));
    plan.push_back(known(op(CMD_ENQUEUE, 3, 3, 1, 8'hff),
                         res(KIND_ENQ_ACK, 1, 3, 3, 0, 8'hff, 0)));
    plan.push_back(known(op(CMD_FREE, 0, 2, 1, 8'h00), res(KIND_FREED, 0, 0, 2, 1, 8'h00, 0)));
    plan.push_back(plain(op(CMD_UNKNOWN, 1, 2, 1, 8'h5a)));
    plan.push_back(plain(op(CMD_ROUND, 0, 0, 0, 8'h00)));
    plan.push_back(plain(op(CMD_FREE, 0, 1, 0, 8'h00)));
    plan.push_back(plain(op(CMD_FREE, 0, 3, 0, 8'h00)));
    // Fill one queue to the brim, then overflow it.
    for (k = 1; k <= QDEPTH; k++)
      plan.push_back(plain(op(CMD_ENQUEUE, 2, 0, 0, 8'(k * 17))));
    plan.push_back(known(op(CMD_ENQUEUE, 2, 0, 0, 8'h99),
                         res(KIND_ENQ_ACK, 0, 2, 0, 0, 8'h99, 0)));
    // Head-of-line blocking once both slots of the destination are taken.
    plan.push_back(plain(op(CMD_ROUND, 0, 0, 0, 8'h00)));
    // No usable slots: nothing can move.
    plan.push_back(setting(CFG_SLOTS_IN_USE, 5'd0));
    plan.push_back(known(op(CMD_ROUND, 0, 0, 0, 8'h00), res(KIND_DONE, 1, 0, 0, 0, 8'h00, 0)));
    // Out-of-range slot and port counts, start port beyond the active ports.
    plan.push_back(setting(CFG_SLOTS_IN_USE, 5'd3));
    plan.push_back(setting(CFG_ACTIVE_PORTS, 5'd0));
    plan.push_back(setting(CFG_EVENTS_PER_PORT, 5'd1));
    plan.push_back(plain(op(CMD_ROUND, 0, 0, 0, 8'h00)));
    // A zero or negative move limit lets nothing through.
    plan.push_back(setting(CFG_ACTIVE_PORTS, 5'd7));
    plan.push_back(setting(CFG_EVENTS_PER_PORT, 5'd0));
    plan.push_back(known(op(CMD_ROUND, 0, 0, 0, 8'h00), res(KIND_DONE, 1, 0, 0, 0, 8'h00, 0)));
    plan.push_back(setting(CFG_EVENTS_PER_PORT, 5'h10));
    plan.push_back(known(op(CMD_ROUND, 0, 0, 0, 8'h00), res(KIND_DONE, 1, 0, 0, 0, 8'h00, 0)));
    // Largest limit, then back to unlimited.
    plan.push_back(setting(CFG_EVENTS_PER_PORT, 5'd15));
    plan.push_back(setting(CFG_ACTIVE_PORTS, 5'd4));
    plan.push_back(plain(op(CMD_FREE, 0, 0, 0, 8'h00)));
    plan.push_back(plain(op(CMD_FREE, 0, 0, 1, 8'h00)));
    plan.push_back(plain(op(CMD_ROUND, 0, 0, 0, 8'h00)));
    plan.push_back(setting(CFG_EVENTS_PER_PORT, 5'h1f));
    plan.push_back(plain(op(CMD_FREE, 0, 0, 1, 8'h00)));

    foreach (plan[r]) begin
      if (plan[r].is_cfg)
        write_register(plan[r].idx, plan[r].value);
      else
        send_item(plan[r].item, plan[r].has_lit, plan[r].lit);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          p_val = 5'd4; s_val = 5'd2; l_val = 5'h1f;
        end
        1: begin
          p_val = 5'd1; s_val = 5'd1; l_val = 5'd1;
        end
        2: begin
          p_val = 5'd4; s_val = 5'd2; l_val = 5'd8;
        end
        default: begin
          p_val = 5'($urandom_range(0, 7));
          s_val = ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom_range(1, 3));
          if ($urandom_range(0, 2) == 0)
            l_val = 5'($urandom_range(0, 31));
          else
            l_val = $urandom_range(0, 1) ? 5'h1f : 5'($urandom_range(1, 8));
        end
      endcase
      write_register(CFG_ACTIVE_PORTS, p_val);
      write_register(CFG_SLOTS_IN_USE, s_val);
      write_register(CFG_EVENTS_PER_PORT, l_val);

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        it.port = 2'($urandom_range(0, 3));
        it.dest = 2'($urandom_range(0, 3));
        it.slot = 1'($urandom_range(0, 1));
        it.payload = 8'($urandom_range(0, 255));
        if (pick < 38) begin
          it.cmd = CMD_ENQUEUE;
        end else if (pick < 70) begin
          it.cmd = CMD_FREE;
          // Mostly free a slot that is really taken, so traffic keeps moving.
          busy_codes.delete();
          for (k = 0; k < PORTS * SLOTS; k++)
            if (slot_taken[k / SLOTS][k % SLOTS]) busy_codes.push_back(k);
          if (busy_codes.size() != 0 && $urandom_range(0, 3) != 0) begin
            k = busy_codes[$urandom_range(0, busy_codes.size() - 1)];
            it.dest = 2'(k / SLOTS);
            it.slot = 1'(k % SLOTS);
          end
        end else if (pick < 96) begin
          it.cmd = CMD_ROUND;
        end else begin
          it.cmd = CMD_UNKNOWN;
        end
        send_item(it, 1'b0, '0);
        if (it.cmd != CMD_UNKNOWN) sent++;
      end
    end

    wait_idle();
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                awaited_results.size()));
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #WATCHDOG_NS;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
design/rrca_pkg.sv
design/rrca_fifo.sv
design/rrca_front.sv
design/rrca_engine.sv
design/round_robin_crossbar_arbiter_unit.sv
tb/round_robin_crossbar_arbiter_unit_test.sv
